// ===== rtl/core/lbp_pkg.sv =====
// Package with sizes, codes and types shared by the LBP filter files.
`timescale 1ns / 1ps
`default_nettype none
package lbp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIXEL_BITS = 8;

  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int COORD_W    = 10;
  localparam int CODE_W     = 8;
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(480);

  // Result queue between the window stage and the output channel.
  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [CODE_W-1:0]  pixel_out;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               last_of_run;
  } res_t;

  // Up to two results pushed in one cycle, in output order.
  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } push_t;

endpackage
`default_nettype wire

// ===== rtl/core/lbp_ifs.sv =====
// Valid/ready channel interfaces for the pixel input and the result output.
`timescale 1ns / 1ps
`default_nettype none
interface lbp_pix_if;
  logic                            valid;
  logic                            ready;
  logic [lbp_pkg::PIXEL_BITS-1:0]  pixel_in;
  logic                            frame_start;

  modport source (output valid, output pixel_in, output frame_start, input ready);
  modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface lbp_res_if;
  logic                            valid;
  logic                            ready;
  logic [lbp_pkg::CODE_W-1:0]      pixel_out;
  logic [lbp_pkg::COORD_W-1:0]     out_row;
  logic [lbp_pkg::COORD_W-1:0]     out_col;
  logic                            last_of_run;

  modport source (output valid, output pixel_out, output out_row, output out_col,
                  output last_of_run, input ready);
  modport sink   (input valid, input pixel_out, input out_row, input out_col,
                  input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lbp_ram.sv =====
// Generic simple dual-port RAM with registered, read-first output.
`timescale 1ns / 1ps
`default_nettype none
module lbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lbp_res_queue.sv =====
// Small result queue: takes up to two results a cycle, sends one a cycle while the output is ready.
`timescale 1ns / 1ps
`default_nettype none
module lbp_res_queue (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lbp_pkg::push_t               push_i,
  output logic [lbp_pkg::Q_CNT_W-1:0]       count_o,
  lbp_res_if.source                         res_o
);
  import lbp_pkg::*;

  res_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               pop;
  logic [Q_PTR_W-1:0] wr_ptr_nxt;
  res_t               head;

  assign head        = mem_q[rd_ptr_q];
  assign pop         = res_o.valid && res_o.ready;
  assign wr_ptr_nxt  = wr_ptr_q + Q_PTR_W'(1);

  assign res_o.valid       = (cnt_q != '0);
  assign res_o.pixel_out   = head.pixel_out;
  assign res_o.out_row     = head.out_row;
  assign res_o.out_col     = head.out_col;
  assign res_o.last_of_run = head.last_of_run;
  assign count_o           = cnt_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q + Q_PTR_W'(push_i.num);
    rd_ptr_d = pop ? rd_ptr_q + Q_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + Q_CNT_W'(push_i.num) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lbp_3x3_pixel_filter.sv =====
// Top level of the 3x3 local binary pattern filter on a raster pixel stream.
//
// Pixels enter one per cycle in raster order while ready is high; frame_start
// places a pixel at row 0, column 0. Each accepted pixel reads its column from
// two 1024-entry line stores in the cycle it is taken, and in the next cycle
// the 3x3 window shifts, eight compares form the code and the column is
// written back. Results leave through an eight-entry queue, one per cycle
// while the output is ready; a pixel that yields two results (an interior
// result plus itself as a border pixel, as on the last column and the last
// row) therefore needs one extra output transfer, and the output port sets the
// sustained rate. The line stores need no clearing after reset: an entry is
// always written before a result can depend on it. Image width and height must
// be written through the configuration port only while the block is idle;
// the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module lbp_3x3_pixel_filter (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lbp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [lbp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  lbp_pix_if.sink                              pix_i,
  lbp_res_if.source                            res_o
);
  import lbp_pkg::*;

  // Configuration and position.
  logic [SIZE_W-1:0]     width_q, height_q;
  logic [SIZE_W-1:0]     w_eff, h_eff;
  logic [COORD_W-1:0]    row_q, row_d, col_q, col_d;
  logic [COORD_W-1:0]    r0, c0, r_cur, c_cur;
  logic [SIZE_W-1:0]     c_inc, r_inc;
  logic                  accept;
  logic                  is_int, is_bord, fwd;

  // Window stage.
  logic                  s1_vld_q;
  logic [PIXEL_BITS-1:0] s1_pix_q;
  logic [COORD_W-1:0]    s1_row_q, s1_col_q;
  logic                  s1_int_q, s1_bord_q, s1_fwd_q;
  logic [PIXEL_BITS-1:0] win_q [9];
  logic [PIXEL_BITS-1:0] win_d [9];
  logic [PIXEL_BITS-1:0] wr_up_q, wr_mid_q;
  logic [PIXEL_BITS-1:0] up_rd, mid_rd, up_val, mid_val;
  logic [CODE_W-1:0]     code;
  res_t                  int_res, bord_res;
  push_t                 push;
  logic [Q_CNT_W-1:0]    q_cnt;
  logic [Q_CNT_W:0]      q_need;

  assign accept = pix_i.valid && pix_i.ready;

  // Keep room for every result still in flight plus the two of a new pixel.
  assign q_need      = {1'b0, q_cnt} + (s1_vld_q ? (Q_CNT_W+1)'(2) : '0);
  assign pix_i.ready = (q_need <= (Q_CNT_W+1)'(Q_DEPTH - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = SIZE_W'(1);
    end else if (width_q > SIZE_W'(MAX_WIDTH)) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = SIZE_W'(1);
    end else if (height_q > SIZE_W'(MAX_HEIGHT)) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  // Position of the arriving pixel and of the one after it.
  always_comb begin
    r0    = pix_i.frame_start ? '0 : row_q;
    c0    = pix_i.frame_start ? '0 : col_q;
    c_cur = ({1'b0, c0} >= w_eff) ? '0 : c0;
    r_cur = ({1'b0, r0} >= h_eff) ? '0 : r0;
    is_int  = (r_cur >= COORD_W'(2)) && (c_cur >= COORD_W'(2));
    is_bord = (r_cur == '0) || (c_cur == '0) ||
              ({1'b0, r_cur} == h_eff - SIZE_W'(1)) ||
              ({1'b0, c_cur} == w_eff - SIZE_W'(1));
    // The window stage writes this column at the same edge as this read.
    fwd   = s1_vld_q && (s1_col_q == c_cur);
    c_inc = {1'b0, c_cur} + SIZE_W'(1);
    r_inc = {1'b0, r_cur} + SIZE_W'(1);
    if (c_inc >= w_eff) begin
      col_d = '0;
      row_d = (r_inc >= h_eff) ? '0 : r_inc[COORD_W-1:0];
    end else begin
      col_d = c_inc[COORD_W-1:0];
      row_d = r_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      if (accept) begin
        row_q <= row_d;
        col_q <= col_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pix_i.pixel_in;
      s1_row_q  <= r_cur;
      s1_col_q  <= c_cur;
      s1_int_q  <= is_int;
      s1_bord_q <= is_bord;
      s1_fwd_q  <= fwd;
    end
    if (s1_vld_q) begin
      wr_up_q  <= mid_val;
      wr_mid_q <= s1_pix_q;
    end
  end

  lbp_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_upper (
    .clk_i   (clk_i),
    .we_i    (s1_vld_q),
    .waddr_i (s1_col_q[ADDR_W-1:0]),
    .wdata_i (mid_val),
    .re_i    (accept),
    .raddr_i (c_cur[ADDR_W-1:0]),
    .rdata_o (up_rd)
  );

  lbp_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_middle (
    .clk_i   (clk_i),
    .we_i    (s1_vld_q),
    .waddr_i (s1_col_q[ADDR_W-1:0]),
    .wdata_i (s1_pix_q),
    .re_i    (accept),
    .raddr_i (c_cur[ADDR_W-1:0]),
    .rdata_o (mid_rd)
  );

  // Window shift, code and results of the pixel in the window stage.
  always_comb begin
    up_val  = s1_fwd_q ? wr_up_q  : up_rd;
    mid_val = s1_fwd_q ? wr_mid_q : mid_rd;
    for (int i = 0; i < 3; i++) begin
      win_d[i*3]     = win_q[i*3 + 1];
      win_d[i*3 + 1] = win_q[i*3 + 2];
    end
    win_d[2] = up_val;
    win_d[5] = mid_val;
    win_d[8] = s1_pix_q;
    for (int i = 0; i < 4; i++) begin
      code[i]     = (win_d[i]     >= win_d[4]);
      code[i + 4] = (win_d[i + 5] >= win_d[4]);
    end

    int_res.pixel_out    = code;
    int_res.out_row      = s1_row_q - COORD_W'(1);
    int_res.out_col      = s1_col_q - COORD_W'(1);
    int_res.last_of_run  = !s1_bord_q;
    bord_res.pixel_out   = s1_pix_q[CODE_W-1:0];
    bord_res.out_row     = s1_row_q;
    bord_res.out_col     = s1_col_q;
    bord_res.last_of_run = 1'b1;

    push.num    = s1_vld_q ? (2'(s1_int_q) + 2'(s1_bord_q)) : 2'd0;
    push.first  = s1_int_q ? int_res : bord_res;
    push.second = bord_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_vld_q) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  lbp_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .count_o (q_cnt),
    .res_o   (res_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/lbp_checker.sv =====
// Port-level checks of the LBP filter and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lbp_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_i,
  input wire logic                           out_valid_i,
  input wire logic                           out_ready_i,
  input wire logic [lbp_pkg::CODE_W-1:0]     out_pixel_i,
  input wire logic [lbp_pkg::COORD_W-1:0]    out_row_i,
  input wire logic [lbp_pkg::COORD_W-1:0]    out_col_i,
  input wire logic                           out_last_i
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_pixel_i) && $stable(out_row_i) &&
                                    $stable(out_col_i) && $stable(out_last_i))
    else $error("result payload changed while stalled");

  // The partner of a result that is not last of its run is already queued.
  a_run_partner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i)
    else $error("second result of a pixel missing");

  // An empty output starts up again only from a pixel transaction that has passed the window stage.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result appeared without a matching pixel");

endmodule

bind lbp_3x3_pixel_filter lbp_checker u_lbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_pixel_i (res_o.pixel_out),
  .out_row_i   (res_o.out_row),
  .out_col_i   (res_o.out_col),
  .out_last_i  (res_o.last_of_run)
);
`default_nettype wire
